>>> sv/ra2_pkg.sv
// Shared constants and types for the rational atan2 approximation pipeline.
package ra2_pkg;

  // Default configuration
  localparam int unsigned InputWidthDef    = 16;
  localparam int unsigned AngleFracBitsDef = 13;
  localparam int unsigned AngleW           = 16;

  // Ratio in Q16, 0..1.0 inclusive
  localparam int unsigned RW = 17;

  // Approximation coefficients
  localparam logic [11:0] K1_Q16 = 12'd3297;
  localparam logic [18:0] K2_Q16 = 19'd458020;
  localparam logic [10:0] K3_Q32 = 11'd1351;
  localparam logic [17:0] K4_Q16 = 18'd186415;
  localparam logic [15:0] K5_Q16 = 16'd54159;
  localparam logic [13:0] K6_Q16 = 14'd9641;
  localparam logic [15:0] K7_Q16 = 16'd42236;

  // Angle constants, Q28
  localparam int unsigned MagW = 30;
  localparam logic [MagW-1:0] PI_Q28  = 30'd843314857;
  localparam logic [MagW-1:0] PIH_Q28 = 30'd421657428;

  // Datapath widths of the rational evaluation
  localparam int unsigned PRawW = 31;
  localparam int unsigned PW    = 16;
  localparam int unsigned RrW   = 34;
  localparam int unsigned K5rW  = 33;
  localparam int unsigned K6rW  = 31;
  localparam int unsigned QuadW = 35;
  localparam int unsigned K7rrW = 50;
  localparam int unsigned ProdW = 49;
  localparam int unsigned QW    = 17;
  localparam int unsigned NumW  = 52;
  localparam int unsigned DenW  = 34;
  localparam int unsigned DvdW  = 64;

  // Quotient bits of the final division (Q28 value stays below 2^30)
  localparam int unsigned VQuotW = 30;

  // Octant and quadrant information that travels with each sample
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic swap;
  } oct_t;

  // Side information through the ratio divider
  typedef struct packed {
    oct_t oct;
    logic zero;
  } ratio_side_t;

endpackage

>>> sv/ra2_if.sv
// Valid/ready channel interfaces for samples and angles.
interface ra2_in_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] y_value;
  logic signed [W-1:0] x_value;

  modport source (output valid, output y_value, output x_value, input ready);
  modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface ra2_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

>>> sv/ra2_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module ra2_div #(
  parameter int unsigned DIVISOR_W = 16,
  parameter int unsigned QUOT_W    = 17,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [DIVISOR_W-1:0] rem_i,
  input  logic [QUOT_W-1:0]    low_i,
  input  logic [DIVISOR_W-1:0] div_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [QUOT_W-1:0]    quot_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 vld_q  [QUOT_W];
  logic [DIVISOR_W-1:0] rem_q  [QUOT_W];
  logic [QUOT_W-1:0]    low_q  [QUOT_W];
  logic [DIVISOR_W-1:0] div_q  [QUOT_W];
  logic [SIDE_W-1:0]    side_q [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    logic                 vld_in;
    logic [DIVISOR_W-1:0] rem_in;
    logic [QUOT_W-1:0]    low_in;
    logic [DIVISOR_W-1:0] div_in;
    logic [SIDE_W-1:0]    side_in;
    logic [DIVISOR_W:0]   trial;
    logic                 take;
    logic [DIVISOR_W-1:0] rem_d;
    logic [QUOT_W-1:0]    low_d;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rem_i;
      assign low_in  = low_i;
      assign div_in  = div_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign low_in  = low_q[i-1];
      assign div_in  = div_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial = {rem_in, low_in[QUOT_W-1]};
      take  = (trial >= {1'b0, div_in});
      rem_d = take ? DIVISOR_W'(trial - {1'b0, div_in}) : DIVISOR_W'(trial);
      low_d = {low_in[QUOT_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        low_q[i]  <= low_d;
        div_q[i]  <= div_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUOT_W-1];
  assign quot_o = low_q[QUOT_W-1];
  assign side_o = side_q[QUOT_W-1];

endmodule

>>> sv/ra2_ratio.sv
// Magnitudes, octant decision and the Q16 min/max ratio.
module ra2_ratio import ra2_pkg::*; #(
  parameter int unsigned INPUT_WIDTH = InputWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [INPUT_WIDTH-1:0] y_i,
  input  logic [INPUT_WIDTH-1:0] x_i,
  output logic                   vld_o,
  output logic [RW-1:0]          r_o,
  output oct_t                   oct_o
);

  localparam int unsigned IW = INPUT_WIDTH;

  logic [IW-1:0] ay, ax;
  logic          vld_q;
  logic [IW-1:0] mn_q, mx_q;
  ratio_side_t   side_q, side_d, side_out;
  logic [RW-1:0] quot;

  // Magnitudes; the most negative code maps to 2^(IW-1) exactly
  always_comb begin
    ay = y_i[IW-1] ? IW'(~y_i + 1'b1) : y_i;
    ax = x_i[IW-1] ? IW'(~x_i + 1'b1) : x_i;
    side_d.oct.yneg = y_i[IW-1];
    side_d.oct.xneg = x_i[IW-1];
    side_d.oct.swap = (ay > ax);
    side_d.zero     = (ay == '0) && (ax == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mn_q   <= (ay > ax) ? ax : ay;
      mx_q   <= (ay > ax) ? ay : ax;
      side_q <= side_d;
    end
  end

  // Divide min * 2^16 by max
  ra2_div #(
    .DIVISOR_W (IW),
    .QUOT_W    (RW),
    .SIDE_W    ($bits(ratio_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vld_q),
    .rem_i  (mn_q >> 1),
    .low_i  ({mn_q[0], (RW-1)'(0)}),
    .div_i  (mx_q),
    .side_i (side_q),
    .vld_o  (vld_o),
    .quot_o (quot),
    .side_o (side_out)
  );

  // Both zero gives a ratio of zero
  assign r_o   = side_out.zero ? '0 : quot;
  assign oct_o = side_out.oct;

endmodule

>>> sv/ra2_poly.sv
// Numerator and denominator of the rational arctangent, five register stages.
module ra2_poly import ra2_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [RW-1:0]   r_i,
  input  oct_t            oct_i,
  output logic            vld_o,
  output logic [DvdW-1:0] dvd_o,
  output logic [DenW-1:0] den_o,
  output oct_t            oct_o
);

  logic [4:0] vld_q;
  oct_t       oct_q [5];

  logic [PRawW-1:0] s1_praw_q;
  logic [RrW-1:0]   s1_rr_q;
  logic [K5rW-1:0]  s1_k5r_q;
  logic [K6rW-1:0]  s1_k6r_q;
  logic [RW-1:0]    s1_r_q;

  logic [PW-1:0]    s2_p_q;
  logic [QuadW-1:0] s2_quad_q;
  logic [K7rrW-1:0] s2_k7rr_q;
  logic [K6rW-1:0]  s2_k6r_q;
  logic [RW-1:0]    s2_r_q;

  logic [ProdW-1:0] s3_prod_q;
  logic [DenW-1:0]  s3_den_q;
  logic [QuadW-1:0] s3_quad_q;

  logic [NumW-1:0]  s4_num_q;
  logic [DenW-1:0]  s4_den_q;

  logic [DvdW-1:0]  s5_dvd_q;
  logic [DenW-1:0]  s5_den_q;

  logic [PRawW:0]   p_sum;
  logic [K7rrW:0]   k7_sum;
  logic [ProdW:0]   prod_sum;
  logic [QW-1:0]    q_rnd;

  always_comb begin
    p_sum    = (PRawW+1)'(s1_praw_q) + (PRawW+1)'(1 << 15);
    k7_sum   = (K7rrW+1)'(s2_k7rr_q) + (K7rrW+1)'(1 << 15);
    prod_sum = (ProdW+1)'(s3_prod_q) + ((ProdW+1)'(1) << 31);
    q_rnd    = QW'(prod_sum >> 32);
  end

  // Advance valid bits and octant flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct_q[0] <= oct_i;
      for (int i = 1; i < 5; i++) begin
        oct_q[i] <= oct_q[i-1];
      end

      // Stage 1: k1 (k2 - r), r^2 and the linear terms
      s1_praw_q <= PRawW'(K1_Q16) * PRawW'(K2_Q16 - 19'(r_i));
      s1_rr_q   <= RrW'(r_i) * RrW'(r_i);
      s1_k5r_q  <= K5rW'(K5_Q16) * K5rW'(r_i);
      s1_k6r_q  <= K6rW'(K6_Q16) * K6rW'(r_i);
      s1_r_q    <= r_i;

      // Stage 2: round p to Q16, quadratic in Q32, k7 r^2
      s2_p_q    <= PW'(p_sum >> 16);
      s2_quad_q <= (QuadW'(K4_Q16) << 16) + QuadW'(s1_k5r_q) + QuadW'(s1_rr_q);
      s2_k7rr_q <= K7rrW'(K7_Q16) * K7rrW'(s1_rr_q);
      s2_k6r_q  <= s1_k6r_q;
      s2_r_q    <= s1_r_q;

      // Stage 3: p (k3 + r) and the denominator in Q32
      s3_prod_q <= ProdW'(s2_p_q) * ProdW'({s2_r_q, 16'd0} + 33'(K3_Q32));
      s3_den_q  <= (DenW'(1) << 32) + DenW'(s2_k6r_q) + DenW'(k7_sum >> 16);
      s3_quad_q <= s2_quad_q;

      // Stage 4: round to Q16 and multiply by the quadratic
      s4_num_q  <= NumW'(q_rnd) * NumW'(s3_quad_q);
      s4_den_q  <= s3_den_q;

      // Stage 5: dividend for a rounded Q28 quotient
      s5_dvd_q  <= (DvdW'(s4_num_q) << 12) + DvdW'(s4_den_q >> 1);
      s5_den_q  <= s4_den_q;
    end
  end

  assign vld_o = vld_q[4];
  assign dvd_o = s5_dvd_q;
  assign den_o = s5_den_q;
  assign oct_o = oct_q[4];

endmodule

>>> sv/ra2_fold.sv
// Octant and quadrant fold, rounding, sign and the output register.
module ra2_fold import ra2_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [MagW-1:0]   v_i,
  input  oct_t              oct_i,
  output logic              vld_o,
  output logic [AngleW-1:0] angle_o
);

  localparam int unsigned SH = 28 - ANGLE_FRAC_BITS;
  localparam logic [MagW:0] HALF = ((MagW+1)'(1) << SH) >> 1;

  logic [3:0]        vld_q;
  oct_t              oct1_q, oct2_q, oct3_q;
  logic [MagW-1:0]   mag1_q, mag2_q;
  logic [MagW:0]     ang_q;
  logic [AngleW-1:0] angle_q;
  logic [MagW:0]     rnd;

  assign rnd = ((MagW+1)'(mag2_q) + HALF) >> SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Fold into the octant: pi/2 - a when |y| > |x|
      mag1_q <= !oct_i.swap ? v_i : ((v_i < PIH_Q28) ? PIH_Q28 - v_i : '0);
      oct1_q <= oct_i;
      // Fold into the quadrant: pi - that when x < 0
      mag2_q <= !oct1_q.xneg ? mag1_q : ((mag1_q < PI_Q28) ? PI_Q28 - mag1_q : '0);
      oct2_q <= oct1_q;
      // Round half up to the output fraction
      ang_q  <= rnd;
      oct3_q <= oct2_q;
      // Apply the sign of y
      angle_q <= oct3_q.yneg ? AngleW'(~ang_q + 1'b1) : AngleW'(ang_q);
    end
  end

  assign vld_o   = vld_q[3];
  assign angle_o = angle_q;

endmodule

>>> sv/rational_atan2_approximation.sv
// Top level of the pipelined four-quadrant rational arctangent.
//
// Takes a signed (y, x) pair and returns atan2(y, x) in radians as signed
// Q(16-ANGLE_FRAC_BITS).ANGLE_FRAC_BITS (Q3.13 by default), -pi..+pi. The
// datapath is a fixed pipeline: one register stage for magnitudes, 17 stages
// of the min/max ratio divider (one quotient bit each), five multiply stages
// for the rational approximation, 30 stages of the final divider and four
// stages of fold, rounding and sign. One transaction is accepted every
// clock unless held; the whole pipeline holds when the output is valid
// and not taken, so ready on the input follows ready on the output. Both
// inputs zero give angle 0; y zero with x negative gives +pi.
module rational_atan2_approximation import ra2_pkg::*; #(
  parameter int unsigned INPUT_WIDTH     = InputWidthDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ra2_in_if.sink    sample_i,
  ra2_out_if.source result_o
);

  logic              en;
  logic              r_vld, p_vld, v_vld, o_vld;
  logic [RW-1:0]     r;
  oct_t              r_oct, p_oct, v_oct;
  logic [DvdW-1:0]   dvd;
  logic [DenW-1:0]   den;
  logic [VQuotW-1:0] v28;
  logic [AngleW-1:0] angle;

  // Hold every stage while a result waits
  assign en             = !o_vld || result_o.ready;
  assign sample_i.ready = en;

  ra2_ratio #(
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sample_i.valid),
    .y_i    (sample_i.y_value),
    .x_i    (sample_i.x_value),
    .vld_o  (r_vld),
    .r_o    (r),
    .oct_o  (r_oct)
  );

  ra2_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (r_vld),
    .r_i    (r),
    .oct_i  (r_oct),
    .vld_o  (p_vld),
    .dvd_o  (dvd),
    .den_o  (den),
    .oct_o  (p_oct)
  );

  // Rounded Q28 quotient of numerator over denominator
  ra2_div #(
    .DIVISOR_W (DenW),
    .QUOT_W    (VQuotW),
    .SIDE_W    ($bits(oct_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p_vld),
    .rem_i  (DenW'(dvd >> VQuotW)),
    .low_i  (dvd[VQuotW-1:0]),
    .div_i  (den),
    .side_i (p_oct),
    .vld_o  (v_vld),
    .quot_o (v28),
    .side_o (v_oct)
  );

  ra2_fold #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v_vld),
    .v_i     (v28),
    .oct_i   (v_oct),
    .vld_o   (o_vld),
    .angle_o (angle)
  );

  assign result_o.valid = o_vld;
  assign result_o.angle = angle;

endmodule

>>> bench/rational_atan2_approximation_test.sv
// Testbench for the pipelined rational atan2 approximation block.
module rational_atan2_approximation_test import ra2_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Latency    = 57;
  localparam int unsigned StallLimit = 20000;

  // Sender idle and receiver stall percentages of the random phases
  localparam int unsigned PctSend[4] = '{0, 55, 0, 32};
  localparam int unsigned PctTake[4] = '{0, 0, 55, 32};

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] x;
    bit                 known;
    logic signed [15:0] angle;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ra2_in_if #(.W(16)) sample_if ();
  ra2_out_if          angle_if ();

  rational_atan2_approximation dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (angle_if.source)
  );

  always #5 clk_i = ~clk_i;

  logic signed [15:0] angle_queue[$];
  int unsigned        mismatch_count = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        take_stall_pct = 0;
  bit                 hold_off = 1'b0;
  int unsigned        quiet_cycles = 0;

  sample_row_t sample_table[] = '{
    '{16'sd0, 16'sd0, 1'b1, 16'sd0},
    '{16'sd0, 16'sd1000, 1'b1, 16'sd0},
    '{16'sd0, -16'sd1000, 1'b1, 16'sd25736},
    '{16'sd0, -16'sd32768, 1'b1, 16'sd25736},
    '{16'sd0, 16'sd32767, 1'b1, 16'sd0},
    '{16'sd32767, 16'sd0, 1'b0, 16'sd0},
    '{-16'sd32768, 16'sd0, 1'b0, 16'sd0},
    '{16'sd1, 16'sd0, 1'b0, 16'sd0},
    '{-16'sd1, 16'sd0, 1'b0, 16'sd0},
    '{16'sd100, 16'sd100, 1'b0, 16'sd0},
    '{-16'sd100, 16'sd100, 1'b0, 16'sd0},
    '{16'sd100, -16'sd100, 1'b0, 16'sd0},
    '{-16'sd100, -16'sd100, 1'b0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
    '{16'sd32767, -16'sd32768, 1'b0, 16'sd0},
    '{-16'sd32768, 16'sd32767, 1'b0, 16'sd0},
    '{16'sd32767, 16'sd32767, 1'b0, 16'sd0},
    '{16'sd1, 16'sd32767, 1'b0, 16'sd0},
    '{16'sd32767, 16'sd1, 1'b0, 16'sd0},
    '{-16'sd1, -16'sd32768, 1'b0, 16'sd0},
    '{16'sd12345, -16'sd23456, 1'b0, 16'sd0},
    '{-16'sd23456, 16'sd12345, 1'b0, 16'sd0},
    '{16'sd21845, 16'sd0, 1'b0, 16'sd0},
    '{-16'sd1, -16'sd1, 1'b0, 16'sd0}
  };

  function automatic logic [63:0] round_down_shift(logic [63:0] v, int unsigned s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  // Compute the Q3.13 angle from one sample pair
  function automatic logic signed [15:0] atan2_angle(logic signed [15:0] y,
                                                     logic signed [15:0] x);
    logic [63:0] ay, ax, hi, lo, r, p, q, quad, num, den, v28, mag, ang;
    ay = y[15] ? 64'(-$signed(17'(y))) : 64'(y[15:0]);
    ax = x[15] ? 64'(-$signed(17'(x))) : 64'(x[15:0]);
    hi = (ay > ax) ? ay : ax;
    lo = (ay > ax) ? ax : ay;
    r  = (hi != 0) ? ((lo << 16) / hi) : 64'd0;
    if (r > 64'd65536) r = 64'd65536;
    p    = round_down_shift(64'(K1_Q16) * (64'(K2_Q16) - r), 16);
    q    = round_down_shift(p * (64'(K3_Q32) + (r << 16)), 32);
    quad = (64'(K4_Q16) << 16) + 64'(K5_Q16) * r + r * r;
    num  = q * quad;
    den  = (64'd1 << 32) + 64'(K6_Q16) * r + round_down_shift(64'(K7_Q16) * r * r, 16);
    v28  = ((num << 12) + (den >> 1)) / den;
    mag  = v28;
    if (ay > ax) mag = (v28 < 64'(PIH_Q28)) ? 64'(PIH_Q28) - v28 : 64'd0;
    if (x[15]) mag = (mag < 64'(PI_Q28)) ? 64'(PI_Q28) - mag : 64'd0;
    ang = round_down_shift(mag, 15);
    if (y[15]) ang = ~ang + 64'd1;
    return ang[15:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [15:0] seen,
                                 logic signed [15:0] want);
    $display("MISMATCH %s: angle %0d, wanted %0d at %0t", what, seen, want, $realtime);
    mismatch_count++;
  endtask

  // Offer one sample and hold it until accepted; valid stays up for the next one
  task automatic send_sample(logic signed [15:0] y, logic signed [15:0] x,
                             bit known, logic signed [15:0] want);
    logic signed [15:0] pred;
    pred = atan2_angle(y, x);
    if (known && pred != want) report_mismatch("table", pred, want);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid   <= 1'b1;
    sample_if.y_value <= y;
    sample_if.x_value <= x;
    do @(posedge clk_i); while (!sample_if.ready);
    angle_queue.push_back(known ? want : pred);
  endtask

  function automatic logic signed [15:0] random_component();
    unique case ($urandom_range(5))
      0: return 16'(-32768 + $urandom_range(2));
      1: return 16'(32765 + $urandom_range(2));
      2: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain_queue();
    while (angle_queue.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, and a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_if.ready <= 1'b0;
    end else begin
      angle_if.ready <= !hold_off && ($urandom_range(99) >= take_stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && angle_if.valid && angle_if.ready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected", angle_if.angle, 16'sd0);
      end else begin
        if (angle_if.angle !== angle_queue[0])
          report_mismatch("result", angle_if.angle, angle_queue[0]);
        void'(angle_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (angle_if.valid && angle_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("rational_atan2_approximation_test NOT OK");
      $finish;
    end
  end

  initial begin
    sample_if.valid   = 1'b0;
    sample_if.y_value = '0;
    sample_if.x_value = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (sample_table[i])
      send_sample(sample_table[i].y, sample_table[i].x, sample_table[i].known,
                  sample_table[i].angle);

    // Sender pauses until every result has come back
    sample_if.valid <= 1'b0;
    drain_queue();

    // Long receiver hold-off while samples keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (120) send_sample(random_component(), random_component(), 1'b0, 16'sd0);
    join

    // Random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = PctSend[ph];
      take_stall_pct = PctTake[ph];
      repeat (120) send_sample(random_component(), random_component(), 1'b0, 16'sd0);
    end
    take_stall_pct = 0;
    sample_if.valid <= 1'b0;

    drain_queue();
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rational_atan2_approximation_test OK");
    end else begin
      $display("rational_atan2_approximation_test NOT OK");
    end
    $finish;
  end
endmodule
